// ----- hdl/nmea_pkg.sv -----
// Shared types and constants for the NMEA GGA/RMC sentence parser.
`default_nettype none
package nmea_pkg;

    localparam int IP_W = 30;   // integer part, saturates at 999999999
    localparam int FR_W = 27;   // fraction part, at most eight digits

    localparam logic [IP_W-1:0] INT_CAP = 30'd999999999;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;

    // field positions
    localparam logic [3:0] F_TIME     = 4'd1;
    localparam logic [3:0] F_GGA_LAT  = 4'd2;
    localparam logic [3:0] F_GGA_NS   = 4'd3;
    localparam logic [3:0] F_GGA_LON  = 4'd4;
    localparam logic [3:0] F_GGA_EW   = 4'd5;
    localparam logic [3:0] F_GGA_FIX  = 4'd6;
    localparam logic [3:0] F_GGA_SAT  = 4'd7;
    localparam logic [3:0] F_GGA_HDOP = 4'd8;
    localparam logic [3:0] F_GGA_ALT  = 4'd9;
    localparam logic [3:0] F_RMC_STAT = 4'd2;
    localparam logic [3:0] F_RMC_LAT  = 4'd3;
    localparam logic [3:0] F_RMC_NS   = 4'd4;
    localparam logic [3:0] F_RMC_LON  = 4'd5;
    localparam logic [3:0] F_RMC_EW   = 4'd6;
    localparam logic [3:0] F_RMC_SPD  = 4'd7;
    localparam logic [3:0] F_RMC_CRS  = 4'd8;
    localparam logic [3:0] F_RMC_DATE = 4'd9;
    localparam logic [3:0] F_LAST     = 4'd9;
    localparam logic [3:0] F_MAXCNT   = 4'd14;
    localparam logic [3:0] F_STOP     = 4'd15;

    // one event travelling down the conversion pipe
    typedef struct packed {
        logic            valid;
        logic            wr;       // stage a value for fld
        logic            commit;   // line end: commit staged into record
        logic            clear;    // new sentence: drop staged flags
        logic            gga;
        logic            neg;
        logic [3:0]      fld;
        logic [7:0]      letter;
        logic [IP_W-1:0] ip;
        logic [FR_W-1:0] frac;
        logic [3:0]      fcnt;     // 0 integer phase, n: n-1 fraction digits
    } evt_t;

    function automatic logic [FR_W-1:0] pow10_fr(input logic [3:0] n);
        logic [FR_W-1:0] r;
        unique case (n)
            4'd0:    r = 27'd1;
            4'd1:    r = 27'd10;
            4'd2:    r = 27'd100;
            4'd3:    r = 27'd1000;
            4'd4:    r = 27'd10000;
            4'd5:    r = 27'd100000;
            4'd6:    r = 27'd1000000;
            4'd7:    r = 27'd10000000;
            4'd8:    r = 27'd100000000;
            default: r = 27'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/nmea_gga_rmc_parser.sv -----
// Top level: NMEA GGA/RMC sentence parser with held position record.
`default_nettype none
// Takes one ASCII character per item and, for every $GPGGA or $GPRMC line
// that ends in CR or LF, gives one result item carrying the whole held
// record. Throughput is one character per clock unless stalled. A result
// passes through the conversion pipe (fraction scaling, reciprocal divides
// by 100, 10, 60, 1e6 and 390625) and then the held-record register. The
// input stalls only when a committed record reaches the end of the pipe
// while the previous result is still unclaimed. No checksum is checked;
// characters NUL and above 127 are dropped; a line longer than
// MAX_SENTENCE - 1 characters has its tail ignored but still commits at
// the line end.
module nmea_gga_rmc_parser #(
    parameter int MAX_SENTENCE = 128
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] char_byte
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [30:0] latitude, [62:31] longitude, [66:63] fix_quality,
    // [73:67] satellites, [98:74] altitude_cm, [119:99] speed_mph_km,
    // [135:120] course_centideg, [160:136] utc_time, [179:161] date_value,
    // [183:180] zero
    output logic [183:0]      m_tdata,
    output logic [0:0]        m_tuser    // [0] sentence_kind
);
    import nmea_pkg::*;

    localparam int CNT_W = $clog2(MAX_SENTENCE);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_SENTENCE - 1);

    // header position: idle, five header letters, body
    typedef enum logic [2:0] {
        H_IDLE, H_G, H_P, H_KIND, H_K2, H_K3, H_BODY
    } hdr_t;
    typedef enum logic [1:0] {K_NONE, K_GGA, K_RMC} kind_t;

    hdr_t             hdr_reg, hdr_next;
    kind_t            kind_reg, kind_next;
    logic [3:0]       fld_reg, fld_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IP_W-1:0]  ip_reg, ip_next;
    logic [FR_W-1:0]  frac_reg, frac_next;
    logic [3:0]       fcnt_reg, fcnt_next;
    logic             done_reg, done_next;   // number ended, ignore rest of field
    logic [7:0]       letter_reg, letter_next;

    logic             en;
    logic             accept;
    logic [7:0]       c;
    logic             is_digit;
    logic [33:0]      ip_x10;
    logic             skip;
    logic             clear_fld;
    evt_t             ev, close_ev;

    evt_t             e6;
    logic [31:0]      val6;

    // staged field values (no reset: read only when the flag is set)
    logic [31:0]      staged_reg [1:9];
    logic [31:0]      sv_n [1:9];
    logic [9:1]       pres_reg, pres_n;

    // held record
    logic [30:0]      lat_reg, lat_n;
    logic [31:0]      lon_reg, lon_n;
    logic [3:0]       fix_reg, fix_n;
    logic [6:0]       sat_reg, sat_n;
    logic [24:0]      alt_reg, alt_n;
    logic [20:0]      spd_reg, spd_n;
    logic [15:0]      crs_reg, crs_n;
    logic [24:0]      time_reg, time_n;
    logic [18:0]      date_reg, date_n;

    logic             tail_commit;
    logic             m_tvalid_reg;
    logic [183:0]     m_tdata_reg;
    logic [0:0]       m_tuser_reg;

    // stall only when a new record would overwrite an unclaimed result
    assign tail_commit = e6.valid && e6.commit;
    assign en       = !(tail_commit && m_tvalid_reg && !m_tready);
    assign s_tready = en;
    assign accept   = s_tvalid && en;
    assign c        = s_tdata;
    assign is_digit = (c >= CH_0) && (c <= CH_9);
    assign ip_x10   = 34'(ip_reg) * 34'd10 + 34'(c - CH_0);

    // ---------------- character front end ----------------
    always_comb begin
        hdr_next    = hdr_reg;
        kind_next   = kind_reg;
        fld_next    = fld_reg;
        cnt_next    = cnt_reg;
        ip_next     = ip_reg;
        frac_next   = frac_reg;
        fcnt_next   = fcnt_reg;
        done_next   = done_reg;
        letter_next = letter_reg;
        skip        = 1'b0;
        clear_fld   = 1'b0;
        ev          = '0;

        close_ev        = '0;
        close_ev.valid  = 1'b1;
        close_ev.wr     = (letter_reg != 8'd0) && (fld_reg >= F_TIME) && (fld_reg <= F_LAST);
        close_ev.gga    = (kind_reg == K_GGA);
        close_ev.neg    = (letter_reg == CH_MINUS);
        close_ev.fld    = fld_reg;
        close_ev.letter = letter_reg;
        close_ev.ip     = ip_reg;
        close_ev.frac   = frac_reg;
        close_ev.fcnt   = fcnt_reg;

        if (accept && c != CH_NUL && !c[7]) begin
            priority if (c == CH_DOLLAR) begin
                hdr_next  = H_G;
                kind_next = K_NONE;
                fld_next  = 4'd0;
                cnt_next  = CNT_W'(1);
                clear_fld = 1'b1;
                ev.valid  = 1'b1;
                ev.clear  = 1'b1;
            end else if (c == CH_CR || c == CH_LF) begin
                if (hdr_reg == H_BODY) begin
                    ev        = close_ev;
                    ev.commit = 1'b1;
                    clear_fld = 1'b1;
                end
                hdr_next  = H_IDLE;
                kind_next = K_NONE;
            end else if (hdr_reg != H_IDLE && cnt_reg < CNT_LIMIT) begin
                cnt_next = cnt_reg + CNT_W'(1);
                unique case (hdr_reg)
                    H_G: hdr_next = (c == CH_G) ? H_P : H_IDLE;
                    H_P: hdr_next = (c == CH_P) ? H_KIND : H_IDLE;
                    H_KIND: begin
                        hdr_next  = (c == CH_G || c == CH_R) ? H_K2 : H_IDLE;
                        kind_next = (c == CH_G) ? K_GGA :
                                    (c == CH_R) ? K_RMC : K_NONE;
                    end
                    H_K2: hdr_next = (c == ((kind_reg == K_GGA) ? CH_G : CH_M)) ? H_K3 : H_IDLE;
                    H_K3: hdr_next = (c == ((kind_reg == K_GGA) ? CH_A : CH_C)) ? H_BODY : H_IDLE;
                    H_BODY: begin
                        if (fld_reg != F_STOP) begin
                            priority if (c == CH_COMMA) begin
                                ev        = close_ev;
                                clear_fld = 1'b1;
                                if (fld_reg < F_MAXCNT) fld_next = fld_reg + 4'd1;
                            end else if (c == CH_STAR) begin
                                ev        = close_ev;
                                clear_fld = 1'b1;
                                fld_next  = F_STOP;
                            end else if (fld_reg <= F_LAST) begin
                                if (letter_reg == 8'd0) begin
                                    letter_next = c;
                                    skip        = (c == CH_MINUS) || (c == CH_PLUS);
                                end
                                if (!skip && !done_reg) begin
                                    priority if (is_digit) begin
                                        if (fcnt_reg == 4'd0) begin
                                            ip_next = (ip_x10 > 34'(INT_CAP)) ? INT_CAP
                                                                              : ip_x10[IP_W-1:0];
                                        end else if (fcnt_reg < 4'd9) begin
                                            frac_next = frac_reg * 27'd10 + 27'(c - CH_0);
                                            fcnt_next = fcnt_reg + 4'd1;
                                        end
                                    end else if (c == CH_DOT && fcnt_reg == 4'd0) begin
                                        fcnt_next = 4'd1;
                                    end else begin
                                        done_next = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                    default: hdr_next = H_IDLE;
                endcase
                if (hdr_reg != H_BODY && hdr_next == H_IDLE) kind_next = K_NONE;
            end
        end

        if (clear_fld) begin
            ip_next     = '0;
            frac_next   = '0;
            fcnt_next   = 4'd0;
            done_next   = 1'b0;
            letter_next = 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg    <= H_IDLE;
            kind_reg   <= K_NONE;
            fld_reg    <= 4'd0;
            cnt_reg    <= '0;
            ip_reg     <= '0;
            frac_reg   <= '0;
            fcnt_reg   <= 4'd0;
            done_reg   <= 1'b0;
            letter_reg <= 8'd0;
        end else begin
            hdr_reg    <= hdr_next;
            kind_reg   <= kind_next;
            fld_reg    <= fld_next;
            cnt_reg    <= cnt_next;
            ip_reg     <= ip_next;
            frac_reg   <= frac_next;
            fcnt_reg   <= fcnt_next;
            done_reg   <= done_next;
            letter_reg <= letter_next;
        end
    end

    // ---------------- conversion pipe ----------------
    nmea_conv u_conv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_evt  (ev),
        .out_evt (e6),
        .out_val (val6)
    );

    // ---------------- staging and commit ----------------
    always_comb begin
        pres_n = (e6.valid && e6.clear) ? '0 : pres_reg;
        for (int i = 1; i <= 9; i++) begin
            sv_n[i] = staged_reg[i];
            if (e6.valid && e6.wr && e6.fld == 4'(i)) begin
                sv_n[i]   = val6;
                pres_n[i] = 1'b1;
            end
        end

        lat_n  = lat_reg;
        lon_n  = lon_reg;
        fix_n  = fix_reg;
        sat_n  = sat_reg;
        alt_n  = alt_reg;
        spd_n  = spd_reg;
        crs_n  = crs_reg;
        time_n = time_reg;
        date_n = date_reg;

        if (tail_commit) begin
            if (e6.gga) begin
                if (pres_n[1]) time_n = sv_n[1][24:0];
                if (pres_n[2] && pres_n[3])
                    lat_n = (sv_n[3][7:0] == CH_S || sv_n[3][7:0] == CH_W) ?
                            31'(32'd0 - sv_n[2]) : sv_n[2][30:0];
                if (pres_n[4] && pres_n[5])
                    lon_n = (sv_n[5][7:0] == CH_S || sv_n[5][7:0] == CH_W) ?
                            32'd0 - sv_n[4] : sv_n[4];
                if (pres_n[6]) fix_n = sv_n[6][3:0];
                if (pres_n[7]) sat_n = sv_n[7][6:0];
                if (pres_n[9]) alt_n = sv_n[9][24:0];
            end else if (!pres_n[2] || sv_n[2] != 32'(CH_A)) begin
                // status not active: only the fix drops
                fix_n = 4'd0;
            end else begin
                fix_n = 4'd1;
                if (pres_n[1]) time_n = sv_n[1][24:0];
                if (pres_n[3] && pres_n[4])
                    lat_n = (sv_n[4][7:0] == CH_S || sv_n[4][7:0] == CH_W) ?
                            31'(32'd0 - sv_n[3]) : sv_n[3][30:0];
                if (pres_n[5] && pres_n[6])
                    lon_n = (sv_n[6][7:0] == CH_S || sv_n[6][7:0] == CH_W) ?
                            32'd0 - sv_n[5] : sv_n[5];
                if (pres_n[7]) spd_n  = sv_n[7][20:0];
                if (pres_n[8]) crs_n  = sv_n[8][15:0];
                if (pres_n[9]) date_n = sv_n[9][18:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 1; i <= 9; i++) staged_reg[i] <= sv_n[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pres_reg     <= '0;
            lat_reg      <= '0;
            lon_reg      <= '0;
            fix_reg      <= '0;
            sat_reg      <= '0;
            alt_reg      <= '0;
            spd_reg      <= '0;
            crs_reg      <= '0;
            time_reg     <= '0;
            date_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tready) m_tvalid_reg <= 1'b0;
            if (en) begin
                pres_reg <= pres_n;
                lat_reg  <= lat_n;
                lon_reg  <= lon_n;
                fix_reg  <= fix_n;
                sat_reg  <= sat_n;
                alt_reg  <= alt_n;
                spd_reg  <= spd_n;
                crs_reg  <= crs_n;
                time_reg <= time_n;
                date_reg <= date_n;
                if (tail_commit) m_tvalid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en && tail_commit) begin
            m_tdata_reg <= {4'd0, date_n, time_n, crs_n, spd_n, alt_n,
                            sat_n, fix_n, lon_n, lat_n};
            m_tuser_reg <= e6.gga ? 1'b0 : 1'b1;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    // input only backs up behind an unclaimed result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output back-pressure");

    // a committed record always becomes a result
    a_commit_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (tail_commit && en) |=> m_tvalid)
        else $error("commit did not produce a result");

    // sentence body is only entered with a recognised header
    a_body_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (hdr_reg == H_BODY) |-> (kind_reg != K_NONE))
        else $error("body without sentence kind");
`endif

endmodule
`default_nettype wire

// ----- hdl/nmea_conv.sv -----
// Pipelined fixed-point conversion of one closed field.
`default_nettype none
module nmea_conv (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  nmea_pkg::evt_t     in_evt,
    output nmea_pkg::evt_t     out_evt,
    output logic [31:0]        out_val
);
    import nmea_pkg::*;

    // reciprocal multipliers, exact over the operand ranges used here
    localparam logic [30:0] M10     = 31'd214748365;   // >>31, x < 2^27
    localparam logic [30:0] M100    = 31'd1374389535;  // >>37, x < 2^30
    localparam logic [27:0] M1E6    = 28'd140737489;   // >>47, x < 2^27
    localparam logic [30:0] M60     = 31'd1145324613;  // >>36, x < 2^30
    localparam logic [30:0] M390625 = 31'd1441151881;  // >>49, x < 2^30

    evt_t e2_reg, e3_reg, e4_reg, e5_reg, e6_reg;

    // stage 2
    logic [3:0]      sh;
    logic [53:0]     f8_prod;
    logic [60:0]     q100_prod;
    logic [26:0]     f8_2_reg;
    logic [23:0]     q100_2_reg;

    // stage 3
    logic [29:0]     rem_full;
    logic [57:0]     fd10_prod;
    logic [54:0]     t6_prod;
    logic [26:0]     f8r;
    logic [54:0]     r6_prod;
    logic [6:0]      rem_3_reg;
    logic [7:0]      degc_3_reg;
    logic [23:0]     fd10_3_reg;
    logic [6:0]      t6_3_reg;
    logic [6:0]      r6_3_reg;
    logic [37:0]     y_3_reg;

    // stage 4
    logic [60:0]     sq_prod;
    logic [17:0]     ipt;
    logic [24:0]     tv;
    logic [16:0]     ipc;
    logic [29:0]     x_4_reg;
    logic [30:0]     degt_4_reg;
    logic [10:0]     sq_4_reg;
    logic [24:0]     time_4_reg;
    logic [23:0]     centi_4_reg;

    // stage 5
    logic [60:0]     q60_prod;
    logic [10:0]     ips;
    logic [20:0]     spv;
    logic [24:0]     q60_5_reg;
    logic [20:0]     spd_5_reg;
    logic [30:0]     degt_5_reg;
    logic [24:0]     time_5_reg;
    logic [23:0]     centi_5_reg;

    // stage 6
    logic [31:0]     coord;
    logic [31:0]     lat_v, lon_v, alt_mag;
    logic [31:0]     val_next;
    logic [31:0]     val_6_reg;

    always_comb begin
        sh        = 4'd9 - in_evt.fcnt;
        f8_prod   = 54'(in_evt.frac) * 54'(pow10_fr(sh));
        q100_prod = 61'(in_evt.ip) * 61'(M100);

        rem_full  = e2_reg.ip - 30'(q100_2_reg) * 30'd100;
        fd10_prod = 58'(f8_2_reg) * 58'(M10);
        t6_prod   = 55'(f8_2_reg) * 55'(M1E6);
        f8r       = f8_2_reg + 27'd500000;
        r6_prod   = 55'(f8r) * 55'(M1E6);

        sq_prod   = 61'(y_3_reg[37:8]) * 61'(M390625);
        ipt       = (e3_reg.ip > 30'd235961) ? 18'd235961 : e3_reg.ip[17:0];
        tv        = 25'(ipt) * 25'd100 + 25'(t6_3_reg);
        ipc       = (e3_reg.ip > 30'd100001) ? 17'd100001 : e3_reg.ip[16:0];

        q60_prod  = 61'(x_4_reg) * 61'(M60);
        ips       = (e4_reg.ip > 30'd1080) ? 11'd1080 : e4_reg.ip[10:0];
        spv       = 21'(ips) * 21'd1852 + 21'(sq_4_reg);

        coord   = 32'(degt_5_reg) + 32'(q60_5_reg);
        lat_v   = (e5_reg.neg || degt_5_reg == '0) ? 32'd0 :
                  (coord > 32'd900000000) ? 32'd900000000 : coord;
        lon_v   = (e5_reg.neg || degt_5_reg == '0) ? 32'd0 :
                  (coord > 32'd1800000000) ? 32'd1800000000 : coord;
        alt_mag = (centi_5_reg > 24'd10000000) ? 32'd10000000 : 32'(centi_5_reg);

        val_next = 32'(e5_reg.letter);
        if (e5_reg.fld == F_TIME) begin
            val_next = e5_reg.neg ? 32'd0 : 32'(time_5_reg);
        end else if (e5_reg.gga) begin
            priority if (e5_reg.fld == F_GGA_LAT) val_next = lat_v;
            else if (e5_reg.fld == F_GGA_LON) val_next = lon_v;
            else if (e5_reg.fld == F_GGA_FIX)
                val_next = e5_reg.neg ? 32'd0 :
                           (e5_reg.ip > 30'd9) ? 32'd9 : 32'(e5_reg.ip);
            else if (e5_reg.fld == F_GGA_SAT)
                val_next = e5_reg.neg ? 32'd0 :
                           (e5_reg.ip > 30'd99) ? 32'd99 : 32'(e5_reg.ip);
            else if (e5_reg.fld == F_GGA_ALT)
                val_next = e5_reg.neg ? 32'd0 - alt_mag : alt_mag;
            else if (e5_reg.fld == F_GGA_HDOP) val_next = 32'd0;
            else val_next = 32'(e5_reg.letter);
        end else begin
            priority if (e5_reg.fld == F_RMC_LAT) val_next = lat_v;
            else if (e5_reg.fld == F_RMC_LON) val_next = lon_v;
            else if (e5_reg.fld == F_RMC_SPD)
                val_next = e5_reg.neg ? 32'd0 : 32'(spd_5_reg);
            else if (e5_reg.fld == F_RMC_CRS)
                val_next = e5_reg.neg ? 32'd0 :
                           (centi_5_reg > 24'd36000) ? 32'd36000 : 32'(centi_5_reg);
            else if (e5_reg.fld == F_RMC_DATE)
                val_next = e5_reg.neg ? 32'd0 :
                           (e5_reg.ip > 30'd311299) ? 32'd311299 : 32'(e5_reg.ip);
            else val_next = 32'(e5_reg.letter);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e2_reg <= '0;
            e3_reg <= '0;
            e4_reg <= '0;
            e5_reg <= '0;
            e6_reg <= '0;
        end else if (en) begin
            e2_reg <= in_evt;
            e3_reg <= e2_reg;
            e4_reg <= e3_reg;
            e5_reg <= e4_reg;
            e6_reg <= e5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f8_2_reg    <= (in_evt.fcnt == 4'd0) ? 27'd0 : f8_prod[26:0];
            q100_2_reg  <= q100_prod[60:37];

            rem_3_reg   <= rem_full[6:0];
            degc_3_reg  <= (q100_2_reg > 24'd181) ? 8'd181 : q100_2_reg[7:0];
            fd10_3_reg  <= fd10_prod[54:31];
            t6_3_reg    <= t6_prod[53:47];
            r6_3_reg    <= r6_prod[53:47];
            y_3_reg     <= 38'(f8_2_reg) * 38'd1852 + 38'd50000000;

            x_4_reg     <= 30'(rem_3_reg) * 30'd10000000 + 30'(fd10_3_reg) + 30'd30;
            degt_4_reg  <= 31'(degc_3_reg) * 31'd10000000;
            sq_4_reg    <= sq_prod[59:49];
            time_4_reg  <= (tv > 25'd23596099) ? 25'd23596099 : tv;
            centi_4_reg <= 24'(ipc) * 24'd100 + 24'(r6_3_reg);

            q60_5_reg   <= q60_prod[60:36];
            spd_5_reg   <= (spv > 21'd2000000) ? 21'd2000000 : spv;
            degt_5_reg  <= degt_4_reg;
            time_5_reg  <= time_4_reg;
            centi_5_reg <= centi_4_reg;

            val_6_reg   <= val_next;
        end
    end

    assign out_evt = e6_reg;
    assign out_val = val_6_reg;

endmodule
`default_nettype wire

// ----- sim/nmea_gga_rmc_parser_test.sv -----
// Testbench for the NMEA GGA/RMC parser: character stimulus, record prediction, field checks.
`timescale 1ns / 100ps
`default_nettype none
module nmea_gga_rmc_parser_test;
    import nmea_pkg::*;

    // held record slots
    localparam int R_LAT  = 0;
    localparam int R_LON  = 1;
    localparam int R_FIX  = 2;
    localparam int R_SAT  = 3;
    localparam int R_ALT  = 4;
    localparam int R_SPD  = 5;
    localparam int R_CRS  = 6;
    localparam int R_TIME = 7;
    localparam int R_DATE = 8;

    // sentence kinds as tracked while parsing
    localparam logic [1:0] K_NONE = 2'd0;
    localparam logic [1:0] K_GGA  = 2'd1;
    localparam logic [1:0] K_RMC  = 2'd2;

    localparam logic [2:0] HP_IDLE = 3'd0;
    localparam logic [2:0] HP_BODY = 3'd6;
    localparam logic [3:0] FC_DONE = 4'd15;
    localparam int         SENT_MAX = 128;

    typedef struct packed {
        logic         kind;
        logic [183:0] data;
    } record_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [183:0] m_tdata;
    logic [0:0]   m_tuser;

    nmea_gga_rmc_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // predictor state
    logic [2:0]  hdr_pos;
    logic [1:0]  kind;
    logic [3:0]  fld_no;
    logic [7:0]  n_chars;
    logic [31:0] int_acc;
    logic [31:0] frac_acc;
    logic [3:0]  frac_cnt;   // 0 integer digits, n: n-1 fraction digits, 15 number closed
    logic [7:0]  lead_ch;    // first character of the field, 0 while empty
    logic [31:0] staged [10];
    logic [9:0]  staged_ok;
    logic [31:0] rec [9];

    record_t expected_records[$];
    int      n_err;
    int      n_chars_sent;
    int      n_records;
    bit      tx_quiet;
    bit      rx_quiet;
    int      next_gap;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [63:0] p10(input int n);
        logic [63:0] r;
        r = 64'd1;
        for (int i = 0; i < n; i++) r = r * 64'd10;
        return r;
    endfunction

    function automatic logic [63:0] cap(input logic [63:0] v, input logic [63:0] c);
        return (v > c) ? c : v;
    endfunction

    // fraction scaled to eight digits
    function automatic logic [63:0] frac8();
        if (frac_cnt == 4'd0) return 64'd0;
        if (frac_cnt <= 4'd9) return 64'(frac_acc) * p10(9 - int'(frac_cnt));
        return 64'(frac_acc);
    endfunction

    function automatic logic [31:0] to_degrees(input logic [63:0] lim);
        logic [63:0] ip, deg, mins, sc, v;
        ip = 64'(int_acc);
        if (lead_ch == CH_MINUS || ip < 64'd100) return 32'd0;
        deg  = ip / 64'd100;
        sc   = p10(7);
        mins = (ip % 64'd100) * sc + frac8() / 64'd10;
        v    = deg * 64'd10000000 + (mins * 64'd10000000 + 64'd30 * sc) / (64'd60 * sc);
        return 32'(cap(v, lim));
    endfunction

    function automatic logic [63:0] centi();
        return 64'(int_acc) * 64'd100 + (frac8() + 64'd500000) / 64'd1000000;
    endfunction

    function automatic logic [31:0] convert_field(input logic [3:0] f);
        logic        neg;
        logic [31:0] mag;
        neg = (lead_ch == CH_MINUS);
        if (f == F_TIME)
            return neg ? 32'd0 : 32'(cap(64'(int_acc) * 100 + frac8() / 64'd1000000, 23596099));
        if (kind == K_GGA) begin
            case (f)
                F_GGA_LAT:  return to_degrees(64'd900000000);
                F_GGA_LON:  return to_degrees(64'd1800000000);
                F_GGA_FIX:  return neg ? 32'd0 : 32'(cap(64'(int_acc), 9));
                F_GGA_SAT:  return neg ? 32'd0 : 32'(cap(64'(int_acc), 99));
                F_GGA_ALT: begin
                    mag = 32'(cap(centi(), 10000000));
                    return neg ? 32'd0 - mag : mag;
                end
                F_GGA_HDOP: return 32'd0;
                default:    return 32'(lead_ch);
            endcase
        end
        case (f)
            F_RMC_LAT:  return to_degrees(64'd900000000);
            F_RMC_LON:  return to_degrees(64'd1800000000);
            F_RMC_SPD:  return neg ? 32'd0 : 32'(cap(64'(int_acc) * 1852 +
                            (frac8() * 1852 + 64'd50000000) / 64'd100000000, 2000000));
            F_RMC_CRS:  return neg ? 32'd0 : 32'(cap(centi(), 36000));
            F_RMC_DATE: return neg ? 32'd0 : 32'(cap(64'(int_acc), 311299));
            default:    return 32'(lead_ch);
        endcase
    endfunction

    function automatic void clear_number();
        int_acc  = '0;
        frac_acc = '0;
        frac_cnt = '0;
        lead_ch  = '0;
    endfunction

    function automatic void close_field();
        if (lead_ch != 8'd0 && fld_no >= 4'd1 && fld_no <= F_LAST) begin
            staged[fld_no] = convert_field(fld_no);
            staged_ok[fld_no] = 1'b1;
        end
        clear_number();
    endfunction

    function automatic logic [31:0] hemi(input logic [31:0] mag, input logic [31:0] ch);
        return (ch == 32'(CH_S) || ch == 32'(CH_W)) ? 32'd0 - mag : mag;
    endfunction

    function automatic void commit_record();
        if (kind == K_GGA) begin
            if (staged_ok[F_TIME]) rec[R_TIME] = staged[F_TIME];
            if (staged_ok[F_GGA_LAT] && staged_ok[F_GGA_NS])
                rec[R_LAT] = hemi(staged[F_GGA_LAT], staged[F_GGA_NS]);
            if (staged_ok[F_GGA_LON] && staged_ok[F_GGA_EW])
                rec[R_LON] = hemi(staged[F_GGA_LON], staged[F_GGA_EW]);
            if (staged_ok[F_GGA_FIX]) rec[R_FIX] = staged[F_GGA_FIX];
            if (staged_ok[F_GGA_SAT]) rec[R_SAT] = staged[F_GGA_SAT];
            if (staged_ok[F_GGA_ALT]) rec[R_ALT] = staged[F_GGA_ALT];
            return;
        end
        // RMC without an 'A' status only drops the fix
        if (!staged_ok[F_RMC_STAT] || staged[F_RMC_STAT] != 32'(CH_A)) begin
            rec[R_FIX] = 32'd0;
            return;
        end
        rec[R_FIX] = 32'd1;
        if (staged_ok[F_TIME]) rec[R_TIME] = staged[F_TIME];
        if (staged_ok[F_RMC_LAT] && staged_ok[F_RMC_NS])
            rec[R_LAT] = hemi(staged[F_RMC_LAT], staged[F_RMC_NS]);
        if (staged_ok[F_RMC_LON] && staged_ok[F_RMC_EW])
            rec[R_LON] = hemi(staged[F_RMC_LON], staged[F_RMC_EW]);
        if (staged_ok[F_RMC_SPD])  rec[R_SPD]  = staged[F_RMC_SPD];
        if (staged_ok[F_RMC_CRS])  rec[R_CRS]  = staged[F_RMC_CRS];
        if (staged_ok[F_RMC_DATE]) rec[R_DATE] = staged[F_RMC_DATE];
    endfunction

    function automatic void take_digit(input logic [7:0] c);
        logic [3:0] p;
        p = frac_cnt;
        if (lead_ch == 8'd0) begin
            lead_ch = c;
            if (c == CH_MINUS || c == CH_PLUS) return;
        end
        if (p == FC_DONE) return;
        if (c >= CH_0 && c <= CH_9) begin
            if (p == 4'd0)
                int_acc = 32'(cap(64'(int_acc) * 10 + 64'(c - CH_0), 64'(INT_CAP)));
            else if (p < 4'd9) begin
                frac_acc = frac_acc * 10 + 32'(c - CH_0);
                frac_cnt = p + 4'd1;
            end
        end else if (c == CH_DOT && p == 4'd0) begin
            frac_cnt = 4'd1;
        end else begin
            frac_acc = 32'(frac8());
            frac_cnt = FC_DONE;
        end
    endfunction

    function automatic void parser_reset();
        hdr_pos = HP_IDLE;
        kind = K_NONE;
        fld_no = '0;
        n_chars = '0;
        clear_number();
        staged_ok = '0;
        for (int i = 0; i < 10; i++) staged[i] = '0;
        for (int i = 0; i < 9; i++) rec[i] = '0;
    endfunction

    // one accepted character; returns 1 and the record when a line commits
    function automatic bit parse_char(input logic [7:0] c, output record_t r);
        bit ok;
        r = '0;
        if (c == CH_NUL || c > 8'd127) return 0;
        if (c == CH_DOLLAR) begin
            hdr_pos = 3'd1;
            kind = K_NONE;
            fld_no = '0;
            n_chars = 8'd1;
            clear_number();
            staged_ok = '0;
            return 0;
        end
        if (c == CH_CR || c == CH_LF) begin
            if (hdr_pos != HP_BODY) begin
                hdr_pos = HP_IDLE;
                kind = K_NONE;
                return 0;
            end
            close_field();
            commit_record();
            r.kind = kind[1];
            r.data = {4'd0, rec[R_DATE][18:0], rec[R_TIME][24:0], rec[R_CRS][15:0],
                      rec[R_SPD][20:0], rec[R_ALT][24:0], rec[R_SAT][6:0], rec[R_FIX][3:0],
                      rec[R_LON], rec[R_LAT][30:0]};
            hdr_pos = HP_IDLE;
            kind = K_NONE;
            return 1;
        end
        if (hdr_pos == HP_IDLE) return 0;
        if (int'(n_chars) >= SENT_MAX - 1) return 0;
        n_chars++;
        if (hdr_pos < HP_BODY) begin
            case (hdr_pos)
                3'd1: ok = (c == CH_G);
                3'd2: ok = (c == CH_P);
                3'd3: begin
                    ok = (c == CH_G || c == CH_R);
                    kind = (c == CH_G) ? K_GGA : K_RMC;
                end
                3'd4: ok = (c == ((kind == K_GGA) ? CH_G : CH_M));
                default: ok = (c == ((kind == K_GGA) ? CH_A : CH_C));
            endcase
            if (ok) hdr_pos++;
            else begin
                hdr_pos = HP_IDLE;
                kind = K_NONE;
            end
            return 0;
        end
        if (fld_no == F_STOP) return 0;
        if (c == CH_COMMA) begin
            close_field();
            if (fld_no < F_MAXCNT) fld_no++;
            return 0;
        end
        if (c == CH_STAR) begin
            close_field();
            fld_no = F_STOP;
            return 0;
        end
        if (fld_no > F_LAST) return 0;
        take_digit(c);
        return 0;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        n_err++;
    endtask

    function automatic int draw_wait(input bit quiet);
        if (quiet) return 0;
        return $urandom_range(0, 16);
    endfunction

    // send one character; valid stays up only when the next item follows at once
    task automatic send_char(input logic [7:0] c);
        record_t r;
        if (next_gap > 0) repeat (next_gap) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge aclk); while (!s_tready);
        n_chars_sent++;
        if (parse_char(c, r)) begin
            expected_records.push_back(r);
            n_records++;
        end
        next_gap = draw_wait(tx_quiet);
        if (next_gap > 0) s_tvalid <= 1'b0;
    endtask

    task automatic send_line(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    // lower valid and let every expected record come out
    task automatic wait_drained();
        if (next_gap == 0) s_tvalid <= 1'b0;
        next_gap = 1;
        while (expected_records.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // result side: random stalls, each record checked field by field
    initial begin
        localparam int LSB [10] = '{0, 31, 63, 67, 74, 99, 120, 136, 161, 180};
        localparam int WID [10] = '{31, 32, 4, 7, 25, 21, 16, 25, 19, 4};
        string   nm [10];
        record_t want;
        int      stall;
        logic [63:0] g, w;
        nm = '{"latitude", "longitude", "fix_quality", "satellites", "altitude_cm",
               "speed_mph_km", "course_centideg", "utc_time", "date_value", "pad"};
        @(posedge aresetn);
        forever begin
            stall = draw_wait(rx_quiet);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (expected_records.size() == 0) begin
                $display("%0t record with none expected", $realtime);
                n_err++;
            end else begin
                want = expected_records.pop_front();
                if (m_tuser[0] !== want.kind) report("sentence_kind", m_tuser, want.kind);
                for (int i = 0; i < 10; i++) begin
                    g = 64'((m_tdata >> LSB[i]) & ((184'd1 << WID[i]) - 1));
                    w = 64'((want.data >> LSB[i]) & ((184'd1 << WID[i]) - 1));
                    if (g !== w) report(nm[i], g, w);
                end
            end
        end
    end

    // ---- directed tests ----

    task automatic test_common_sentences();
        send_line("$GPGGA,123519.00,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\015\n");
        send_line("$GPRMC,225446.99,A,4916.45,N,12311.12,W,000.5,054.7,191194,020.3,E*68\n");
        send_line("$GPRMC,010203,V,1111.11,S,2222.22,E,1,2,010100\015");
        send_line("$GPGGA,,3345.6789,S,15112.3456,W,,,,-12.345\n");
        send_line("$GPGGA,1.5,3345.6789,,15112.3456,,2,3,,.5\n");
        send_line("$GPRMC,5.,A,,N,,E,,,\n");
    endtask

    task automatic test_limits();
        send_line("$GPGGA,999999999999.999999999,99999999.99999999,N,99999999,E,99,999,1,");
        send_line("99999999.9\n");
        send_line("$GPGGA,1,99.5,N,-5,E,-3,-4,,+7.5\n");
        send_line("$GPGGA,0,0100.0000001,S,0000.00000,W,0,0,,-99999999\n");
        send_line("$GPRMC,+1.5,A,9000.0000,S,18000.0000,W,99999,99999.999,9999999\n");
        send_line("$GPRMC,-1,A,-4807,N,0.5,E,-1,-2,-3\n");
        send_line("$GPRMC,0,A,0,N,0,E,0.00000001,0.004999,0\n");
    endtask

    task automatic test_broken_lines();
        send_line("$GPXYZ,1,2,3\n$GPGGB,1\n$GP\n\n\015$GPRMD,1\n$HPGGA,1\n$GPRRC,1\n");
        send_line("$GPGGA,1,2$GPRMC,2,A\015\n");
        send_line("$GPGGA,12a3.4b5,4807-1,N,,,1x,2.3.4,7e,1..5\n");
        send_line("$GPRMC,1,A,,,,,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,16\n");
        send_line("$GPGGA,7,*,1,2,3\n$GPRMC,8,A*,9\n");
        // NUL and high bytes are dropped anywhere
        send_char(CH_DOLLAR);
        send_char(CH_G);
        send_char(8'h00);
        send_char(CH_P);
        send_char(8'hFF);
        send_line("GGA,1");
        send_char(8'h80);
        send_char(8'hA5);
        send_line("23,,,,,9,\n");
    endtask

    task automatic test_long_line();
        string s;
        s = "$GPGGA,1";
        for (int i = 0; i < 130; i++) s = {s, "0"};
        send_line({s, "\n"});
        s = "$GPRMC,12,A";
        for (int i = 0; i < 60; i++) s = {s, ",7"};
        send_line({s, "\n"});
        s = "$GPGGA,,,,,,,,,";
        for (int i = 0; i < 100; i++) s = {s, "1"};
        send_line({s, "\015\n"});
    endtask

    // pause until every record is out, then carry on
    task automatic test_pause();
        send_line("$GPGGA,111111,1234.5,N,12345.6,W,4,12,1,100\n");
        wait_drained();
        send_line("$GPRMC,222222,A,4321.0,S,05432.1,E,12.3,45.6,311299\n");
        wait_drained();
    endtask

    // ---- random sentences ----

    function automatic string rnd_number(input int max_int);
        string s;
        int    n;
        s = "";
        case ($urandom_range(0, 19))
            0: s = "-";
            1: s = "+";
            default: ;
        endcase
        n = $urandom_range(0, max_int);
        for (int i = 0; i < n; i++) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
        if ($urandom_range(0, 2) != 0) begin
            s = {s, "."};
            n = $urandom_range(0, 10);
            for (int i = 0; i < n; i++) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
        end
        if ($urandom_range(0, 14) == 0) s = $sformatf("%s%c%0d", s, $urandom_range(33, 126),
                                                      $urandom_range(0, 99));
        return s;
    endfunction

    function automatic string rnd_field(input int max_int);
        if ($urandom_range(0, 5) == 0) return "";
        return rnd_number(max_int);
    endfunction

    function automatic string rnd_letter(input string pool);
        if ($urandom_range(0, 5) == 0) return "";
        if ($urandom_range(0, 9) == 0) return $sformatf("%c", $urandom_range(33, 126));
        return $sformatf("%c", pool[$urandom_range(0, pool.len() - 1)]);
    endfunction

    function automatic string rnd_sentence();
        string s;
        int    n;
        if ($urandom_range(0, 1) == 0)
            s = {"$GPGGA,", rnd_field(6), ",", rnd_field(5), ",", rnd_letter("NS"), ",",
                 rnd_field(6), ",", rnd_letter("EW"), ",", rnd_field(2), ",", rnd_field(3),
                 ",", rnd_field(2), ",", rnd_field(9)};
        else
            s = {"$GPRMC,", rnd_field(6), ",", rnd_letter("AAAV"), ",", rnd_field(5), ",",
                 rnd_letter("NS"), ",", rnd_field(6), ",", rnd_letter("EW"), ",",
                 rnd_field(5), ",", rnd_field(4), ",", rnd_field(7)};
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) s = {s, ",", rnd_field(3)};
        if ($urandom_range(0, 2) == 0) s = $sformatf("%s*%02X", s, $urandom_range(0, 255));
        // occasional damage: header letter, a truncated restart
        if ($urandom_range(0, 14) == 0) s[$urandom_range(1, 5)] = $urandom_range(65, 90);
        if ($urandom_range(0, 19) == 0) s = {s.substr(0, $urandom_range(1, s.len() - 1)), s};
        case ($urandom_range(0, 2))
            0: s = {s, "\015\n"};
            1: s = {s, "\n"};
            default: s = {s, "\015"};
        endcase
        return s;
    endfunction

    task automatic send_damaged(input string s);
        int at;
        at = $urandom_range(0, s.len() - 1);
        for (int i = 0; i < s.len(); i++) begin
            if (i == at) send_char(8'($urandom_range(0, 255)));
            send_char(s[i]);
        end
    endtask

    task automatic test_random_traffic();
        int start_chars, start_recs;
        start_chars = n_chars_sent;
        start_recs  = n_records;
        while (n_chars_sent - start_chars < 1250 || n_records - start_recs < 48) begin
            tx_quiet = ($urandom_range(0, 4) == 0);
            rx_quiet = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0: send_damaged(rnd_sentence());
                1: repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)));
                default: send_line(rnd_sentence());
            endcase
        end
        tx_quiet = 0;
        rx_quiet = 0;
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        n_err = 0;
        n_chars_sent = 0;
        n_records = 0;
        tx_quiet = 0;
        rx_quiet = 0;
        next_gap = 0;
        parser_reset();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_common_sentences();
        test_limits();
        test_broken_lines();
        test_long_line();
        test_pause();
        test_random_traffic();

        // let the pipe empty, then allow for its depth
        wait_drained();
        repeat (20) @(posedge aclk);
        if (n_err == 0) begin
            $display("nmea_gga_rmc_parser_test passed");
        end else begin
            $display("nmea_gga_rmc_parser_test failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("nmea_gga_rmc_parser_test failed");
        $finish;
    end

endmodule
`default_nettype wire
